// File: hdl/dftp_pkg.sv
`timescale 1ns / 1ps
// Package with the shared types and constants of the decimal frequency token parser.
package dftp_pkg;

  localparam logic [1:0] PH_SPACES = 2'd0;
  localparam logic [1:0] PH_MHZ    = 2'd1;
  localparam logic [1:0] PH_KHZ    = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] MHZ_MAX  = 16'hFFFF;
  localparam logic [9:0]  KHZ_LIMIT = 10'd1000;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] mhz_acc;
    logic [9:0]  khz_acc;
    logic [1:0]  khz_count;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] mhz;
    logic [9:0]  khz;
  } parse_result_t;

endpackage

// File: hdl/dftp_step.sv
`timescale 1ns / 1ps
// Combinational parse step: next token state and result for one character.
module dftp_step #(
  parameter int KHZ_DIGITS = 3
) (
  input  dftp_pkg::parse_state_t  state,
  input  logic                    start_req,
  input  logic [7:0]              char_code,
  output dftp_pkg::parse_state_t  state_next,
  output logic                    emit,
  output dftp_pkg::parse_result_t result
);

  localparam logic [1:0] DIGITS_W = 2'(KHZ_DIGITS);

  dftp_pkg::parse_state_t cur;
  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] mhz_prod;
  logic [15:0] mhz_digit;
  logic [13:0] khz_prod;
  logic [9:0]  khz_digit;
  logic [1:0]  count_inc;
  logic [13:0] pad_prod;
  logic [9:0]  khz_pad;
  logic        mhz_emit;
  logic [1:0]  mhz_phase;
  logic [15:0] mhz_next;

  always_comb begin
    cur = state;
    if (start_req) begin
      cur.phase     = dftp_pkg::PH_SPACES;
      cur.mhz_acc   = '0;
      cur.khz_acc   = '0;
      cur.khz_count = '0;
    end

    is_digit = (char_code >= dftp_pkg::CH_ZERO) && (char_code <= dftp_pkg::CH_NINE);
    digit    = is_digit ? 4'(char_code - dftp_pkg::CH_ZERO) : 4'd0;

    mhz_prod  = {4'd0, cur.mhz_acc} * 20'd10 + {16'd0, digit};
    mhz_digit = (mhz_prod > {4'd0, dftp_pkg::MHZ_MAX}) ? dftp_pkg::MHZ_MAX : mhz_prod[15:0];

    khz_prod  = {4'd0, cur.khz_acc} * 14'd10 + {10'd0, digit};
    khz_digit = khz_prod[9:0];
    count_inc = cur.khz_count + 2'd1;

    // Pads the kilohertz part with trailing zeros up to the full digit count.
    khz_pad = cur.khz_acc;
    for (int i = 0; i < 3; i++) begin
      pad_prod = {4'd0, khz_pad} * 14'd10;
      if ((i + int'(cur.khz_count)) < KHZ_DIGITS) begin
        khz_pad = pad_prod[9:0];
      end
    end

    // The megahertz step is shared by the space phase and the megahertz phase.
    mhz_emit  = 1'b0;
    mhz_phase = dftp_pkg::PH_MHZ;
    mhz_next  = cur.mhz_acc;
    if (is_digit) begin
      mhz_next = mhz_digit;
    end else if ((char_code == dftp_pkg::CH_DOT) && (cur.mhz_acc != 16'd0)) begin
      mhz_phase = dftp_pkg::PH_KHZ;
    end else begin
      mhz_emit = 1'b1;
    end

    state_next = cur;
    emit       = 1'b0;
    result     = '{status: dftp_pkg::ST_INVALID, mhz: 16'd0, khz: 10'd0};

    unique case (cur.phase)
      dftp_pkg::PH_DONE: begin
      end
      dftp_pkg::PH_SPACES: begin
        if (char_code == dftp_pkg::CH_NUL) begin
          emit             = 1'b1;
          result.status    = dftp_pkg::ST_EMPTY;
          state_next.phase = dftp_pkg::PH_DONE;
        end else if (char_code != dftp_pkg::CH_SPACE) begin
          emit               = mhz_emit;
          state_next.mhz_acc = mhz_next;
          state_next.phase   = mhz_emit ? dftp_pkg::PH_DONE : mhz_phase;
        end
      end
      dftp_pkg::PH_MHZ: begin
        emit               = mhz_emit;
        state_next.mhz_acc = mhz_next;
        state_next.phase   = mhz_emit ? dftp_pkg::PH_DONE : mhz_phase;
      end
      dftp_pkg::PH_KHZ: begin
        if (is_digit) begin
          state_next.khz_acc   = khz_digit;
          state_next.khz_count = count_inc;
          if (count_inc >= DIGITS_W) begin
            emit             = 1'b1;
            result.status    = dftp_pkg::ST_OK;
            result.mhz       = cur.mhz_acc;
            result.khz       = khz_digit;
            state_next.phase = dftp_pkg::PH_DONE;
          end
        end else if ((char_code == dftp_pkg::CH_SPACE) || (char_code == dftp_pkg::CH_NUL)) begin
          emit                 = 1'b1;
          result.status        = dftp_pkg::ST_OK;
          result.mhz           = cur.mhz_acc;
          result.khz           = khz_pad;
          state_next.khz_acc   = khz_pad;
          state_next.khz_count = DIGITS_W;
          state_next.phase     = dftp_pkg::PH_DONE;
        end else begin
          emit             = 1'b1;
          state_next.phase = dftp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/decimal_frequency_token_parser.sv
`timescale 1ns / 1ps
// Top level of the decimal frequency token parser with its input and result registers.
//
// The char channel carries one ASCII character per request, with start_req marking the
// first character of a new token. The result channel carries status, mhz_value and
// khz_value, and a result appears only when a token finishes: at a NUL or bad character,
// at a space after the kilohertz digits, or after the last kilohertz digit.
// A character is taken into an input register, and a single combinational parse step
// then updates the token state and loads the result register once that register is free.
// A result therefore passes through the input register and then the result register.
// The block takes one character every cycle while the result channel is not stalled;
// the state update of the parse step is a loop from the state register back to itself.
// While the result register holds a result that the receiver stalls, the parse step
// waits and char_stall rises once the input register is also full.
// Reset empties both registers and returns the token state to the space-skipping
// phase, so characters after reset are parsed as a new token without a start flag.
module decimal_frequency_token_parser #(
  parameter int KHZ_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic        start_req,
  input  logic [7:0]  char_code,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] mhz_value,
  output logic [9:0]  khz_value
);

  logic                    hold_valid;
  logic                    hold_start;
  logic [7:0]              hold_char;
  dftp_pkg::parse_state_t  state;
  dftp_pkg::parse_state_t  state_next;
  dftp_pkg::parse_result_t step_result;
  logic                    step_emit;
  logic                    out_free;
  logic                    advance;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && out_free;
  assign char_stall = hold_valid && !out_free;

  dftp_step #(
    .KHZ_DIGITS(KHZ_DIGITS)
  ) u_step (
    .state     (state),
    .start_req (hold_start),
    .char_code (hold_char),
    .state_next(state_next),
    .emit      (step_emit),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!char_stall) begin
      hold_valid <= char_valid;
    end
    if (char_valid && !char_stall) begin
      hold_start <= start_req;
      hold_char  <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= dftp_pkg::PH_SPACES;
      state.mhz_acc   <= '0;
      state.khz_acc   <= '0;
      state.khz_count <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && step_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && step_emit) begin
      status    <= step_result.status;
      mhz_value <= step_result.mhz;
      khz_value <= step_result.khz;
    end
  end

`ifndef NO_ASSERTIONS
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == dftp_pkg::ST_OK || status == dftp_pkg::ST_EMPTY ||
                      status == dftp_pkg::ST_INVALID))
    else $error("Result carries an undefined status code.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != dftp_pkg::ST_OK) |-> (mhz_value == 16'd0 && khz_value == 10'd0))
    else $error("A failed token returned nonzero values.");

  a_khz_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == dftp_pkg::ST_OK) |-> (khz_value < dftp_pkg::KHZ_LIMIT))
    else $error("Kilohertz value is out of range.");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> !char_stall)
    else $error("Input stalled with an empty input register.");

  a_idle_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!result_valid && state.phase == dftp_pkg::PH_SPACES))
    else $error("Block not idle after reset.");
`endif

endmodule
